// ----- rtl/irrigation_pump_controller_macros.svh -----
// Assertion macros used by the irrigation pump controller top level.
`ifndef IRRIGATION_PUMP_CONTROLLER_MACROS_SVH
`define IRRIGATION_PUMP_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property at each rising clock edge, skipped while reset is high.
`define IPC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("irrigation_pump_controller: assertion failed");

// Check a property at each rising clock edge, reset included.
`define IPC_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("irrigation_pump_controller: reset assertion failed");

`else

`define IPC_ASSERT(label, prop)
`define IPC_ASSERT_RST(label, prop)

`endif

`endif

// ----- rtl/ipc_pkg.sv -----
// Types, codes and reset values shared by the irrigation pump controller.
`default_nettype none

package ipc_pkg;

   localparam int TIMER_W    = 16;
   localparam int LEVEL_W    = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // Button codes
   localparam logic [1:0] BTN_NONE  = 2'd0;
   localparam logic [1:0] BTN_MODE  = 2'd1;
   localparam logic [1:0] BTN_WATER = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LOW_THRESHOLD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_WATER      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CHECK_INTERVAL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MANUAL_RUN     = 3'd4;

   // Register reset values
   localparam logic [LEVEL_W-1:0] LOW_THRESHOLD_RST  = 7'd40;
   localparam logic [LEVEL_W-1:0] HIGH_THRESHOLD_RST = 7'd70;
   localparam logic [TIMER_W-1:0] MAX_WATER_RST      = 16'd60;
   localparam logic [TIMER_W-1:0] CHECK_INTERVAL_RST = 16'd5;
   localparam logic [TIMER_W-1:0] MANUAL_RUN_RST     = 16'd10;

   typedef struct packed {
      logic [LEVEL_W-1:0] low_threshold;
      logic [LEVEL_W-1:0] high_threshold;
      logic [TIMER_W-1:0] max_water_seconds;
      logic [TIMER_W-1:0] check_interval_seconds;
      logic [TIMER_W-1:0] manual_run_seconds;
   } cfg_type;

   typedef struct packed {
      logic               manual_mode;
      logic               pump_running;
      logic               led_state;
      logic [TIMER_W-1:0] sample_timer;
      logic [TIMER_W-1:0] run_timer;
      logic [LEVEL_W-1:0] held_level;
   } state_type;

   // Packed so that the first field sits in the highest bits
   typedef struct packed {
      logic               second_tick;
      logic [LEVEL_W-1:0] humidity_sample;
      logic [1:0]         button;
   } item_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] humidity_held;
      logic               sampled;
      logic               manual_active;
      logic               indicator_on;
      logic               pump_on;
   } result_type;

   localparam state_type STATE_RST = '{
      manual_mode:  1'b0,
      pump_running: 1'b0,
      led_state:    1'b0,
      sample_timer: CHECK_INTERVAL_RST,
      run_timer:    '0,
      held_level:   '0
   };

   function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
      return (v == {TIMER_W{1'b1}}) ? v : v + {{(TIMER_W-1){1'b0}}, 1'b1};
   endfunction

endpackage

`default_nettype wire

// ----- rtl/irrigation_pump_controller.sv -----
// Top level of the irrigation pump controller: input stage, step, result stage.
// Channel | Direction | Handshake             | Payload
// req     | in        | req_tvalid/req_tready | req_tdata: button, humidity_sample, second_tick
// rsp     | out       | rsp_tvalid/rsp_tready | rsp_tdata: pump_on .. humidity_held
// csr     | in        | csr_we                | csr_index, csr_wdata
// An accepted transaction lands in the input register, and the step logic turns it into a
// result register entry when the result register is empty or rsp_tready is high.
// One transaction per cycle is sustained while rsp_tready stays high.
// A stalled rsp holds the result register, then the input register, then req_tready drops.
// Synchronous reset clears both valid bits, the controller state and the configuration registers.
`default_nettype none
`include "irrigation_pump_controller_macros.svh"

module irrigation_pump_controller (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   // [1:0] button, [8:2] humidity_sample, [9] second_tick, [15:10] ignored
   input  wire logic [ipc_pkg::REQ_DATA_W-1:0]   req_tdata,
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [0] pump_on, [1] indicator_on, [2] manual_active, [3] sampled,
   // [10:4] humidity_held, [15:11] zero
   output      logic [ipc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic                             csr_we,
   input  wire logic [ipc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ipc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ipc_pkg::*;

   localparam int ITEM_W   = $bits(item_type);
   localparam int RESULT_W = $bits(result_type);

   cfg_type    cfg;
   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff, in_item_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_item_ff, out_item_in;
   state_type  state_ff, state_in;
   state_type  step_state;
   result_type step_result;
   logic       advance;
   logic       req_fire;
   logic       step_fire;
   logic       rsp_mirrors_state;
   logic       manual_entry;

   ipc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ipc_step u_step (
      .cur_state (state_ff),
      .cfg       (cfg),
      .item      (in_item_ff),
      .nxt_state (step_state),
      .result    (step_result)
   );

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign step_fire  = in_valid_ff && advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      state_in     = state_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
      end
      if (step_fire) begin
         out_item_in = step_result;
         state_in    = step_state;
         in_valid_in = 1'b0;
      end
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_item_in  = item_type'(req_tdata[ITEM_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RESULT_W){1'b0}}, out_item_ff};

   assign rsp_mirrors_state = out_item_ff.pump_on == state_ff.pump_running &&
                              out_item_ff.manual_active == state_ff.manual_mode &&
                              out_item_ff.humidity_held == state_ff.held_level;
   assign manual_entry      = step_fire && in_item_ff.button == BTN_MODE &&
                              !state_ff.manual_mode;

   // a pending result always mirrors the controller state it left behind
   `IPC_ASSERT(a_rsp_matches_state, rsp_tvalid |-> rsp_mirrors_state)
   // entering manual mode forces the pump off
   `IPC_ASSERT(a_manual_entry_stops_pump, manual_entry |=> (!state_ff.pump_running && state_ff.manual_mode))
   // a sample clears the sample timer
   `IPC_ASSERT(a_sample_clears_timer, (step_fire && step_result.sampled) |=> (state_ff.sample_timer == '0))
   // a stalled result freezes the controller state
   `IPC_ASSERT(a_stall_holds_state, (rsp_tvalid && !rsp_tready) |=> $stable(state_ff))
   // reset empties both stages
   `IPC_ASSERT_RST(a_reset_empties, reset |=> (!rsp_tvalid && req_tready))

endmodule

`default_nettype wire

// ----- rtl/ipc_csr.sv -----
// Configuration register file of the irrigation pump controller.
`default_nettype none

module ipc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [ipc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ipc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output ipc_pkg::cfg_type                      cfg
);
   import ipc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_LOW_THRESHOLD:  cfg_in.low_threshold          = csr_wdata[LEVEL_W-1:0];
            REG_HIGH_THRESHOLD: cfg_in.high_threshold         = csr_wdata[LEVEL_W-1:0];
            REG_MAX_WATER:      cfg_in.max_water_seconds      = csr_wdata[TIMER_W-1:0];
            REG_CHECK_INTERVAL: cfg_in.check_interval_seconds = csr_wdata[TIMER_W-1:0];
            REG_MANUAL_RUN:     cfg_in.manual_run_seconds     = csr_wdata[TIMER_W-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_threshold          <= LOW_THRESHOLD_RST;
         cfg_ff.high_threshold         <= HIGH_THRESHOLD_RST;
         cfg_ff.max_water_seconds      <= MAX_WATER_RST;
         cfg_ff.check_interval_seconds <= CHECK_INTERVAL_RST;
         cfg_ff.manual_run_seconds     <= MANUAL_RUN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/ipc_step.sv -----
// Next-state and result logic for one poll pass of the pump controller.
`default_nettype none

module ipc_step (
   input  ipc_pkg::state_type  cur_state,
   input  ipc_pkg::cfg_type    cfg,
   input  ipc_pkg::item_type   item,
   output ipc_pkg::state_type  nxt_state,
   output ipc_pkg::result_type result
);
   import ipc_pkg::*;

   always_comb begin
      state_type s;
      logic      smp;

      s   = cur_state;
      smp = 1'b0;

      // advance both timers first
      if (item.second_tick) begin
         s.sample_timer = sat_inc(s.sample_timer);
         s.run_timer    = sat_inc(s.run_timer);
      end

      unique case (item.button)
         BTN_MODE: begin
            if (!s.manual_mode) begin
               s.manual_mode  = 1'b1;
               s.pump_running = 1'b0;
            end else begin
               s.manual_mode  = 1'b0;
            end
         end
         BTN_WATER: begin
            if (s.manual_mode) begin
               s.pump_running = 1'b1;
               s.run_timer    = '0;
            end
         end
         default: ;  // no event, or unused code
      endcase

      if (!s.manual_mode) begin
         if (s.sample_timer >= cfg.check_interval_seconds) begin
            s.held_level   = item.humidity_sample;
            s.sample_timer = '0;
            smp            = 1'b1;
            if (s.held_level < cfg.low_threshold && !s.pump_running) begin
               s.pump_running = 1'b1;
               s.led_state    = 1'b1;
               s.run_timer    = '0;
            end
         end
         if (s.pump_running && (s.held_level >= cfg.high_threshold ||
                                s.run_timer >= cfg.max_water_seconds)) begin
            s.pump_running = 1'b0;
            s.led_state    = 1'b0;
         end
      end else begin
         if (s.pump_running && s.run_timer >= cfg.manual_run_seconds) begin
            s.pump_running = 1'b0;
            s.led_state    = 1'b0;
         end
      end

      nxt_state            = s;
      result.pump_on       = s.pump_running;
      result.indicator_on  = s.led_state;
      result.manual_active = s.manual_mode;
      result.sampled       = smp;
      result.humidity_held = s.held_level;
   end

endmodule

`default_nettype wire

// ----- dv/tb_irrigation_pump_controller.sv -----
// Self-checking testbench for the irrigation pump controller: directed table, random phases.
module tb_irrigation_pump_controller;
   timeunit 1ns;
   timeprecision 1ps;

   import ipc_pkg::*;

   localparam int CYCLE_LIMIT       = 1_000_000;
   localparam int DRAIN_CYCLES      = 4;
   localparam int LONG_STALL_CYCLES = 150;
   localparam int PHASE_ITEMS       = 260;

   // Codes the package leaves out: the unused button value and the unmapped register indexes
   localparam logic [1:0]           BTN_SPARE       = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_val;
      item_type              item;
      logic                  has_exp;
      result_type            exp;
   } stim_row_type;

   // item: {second_tick, humidity_sample, button}
   // exp:  {humidity_held, sampled, manual_active, indicator_on, pump_on}
   localparam stim_row_type OPENING_ROWS [28] = '{
      '{ROW_ITEM, '0, '0, '{1'b0, 7'd55, BTN_NONE}, 1'b1, '{7'd55, 1'b1, 1'b0, 1'b0, 1'b0}},
      '{ROW_ITEM, '0, '0, '{1'b0, 7'd20, BTN_NONE}, 1'b1, '{7'd55, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{ROW_ITEM, '0, '0, '{1'b1, 7'd127, BTN_SPARE}, 1'b1, '{7'd55, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{ROW_ITEM, '0, '0, '{1'b1, 7'd0, BTN_WATER}, 1'b1, '{7'd55, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{ROW_ITEM, '0, '0, '{1'b1, 7'd30, BTN_NONE}, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{1'b1, 7'd30, BTN_NONE}, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{1'b1, 7'd30, BTN_NONE}, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{1'b0, 7'd100, BTN_MODE}, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{1'b1, 7'd100, BTN_WATER}, 1'b0, '0},
      '{ROW_CSR, REG_MANUAL_RUN, 16'd2, '0, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{1'b1, 7'd0, BTN_NONE}, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{1'b1, 7'd0, BTN_NONE}, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{1'b0, 7'd0, BTN_WATER}, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{1'b0, 7'd0, BTN_MODE}, 1'b0, '0},
      '{ROW_CSR, REG_HIGH_THRESHOLD, 16'd0, '0, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{1'b0, 7'd64, BTN_NONE}, 1'b0, '0},
      '{ROW_CSR, REG_CHECK_INTERVAL, 16'd0, '0, 1'b0, '0},
      '{ROW_CSR, REG_LOW_THRESHOLD, 16'hFFFF, '0, 1'b0, '0},
      '{ROW_CSR, REG_MAX_WATER, 16'd0, '0, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{1'b0, 7'd126, BTN_NONE}, 1'b1, '{7'd126, 1'b1, 1'b0, 1'b0, 1'b0}},
      '{ROW_CSR, REG_HIGH_THRESHOLD, 16'hFFFF, '0, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{1'b0, 7'd126, BTN_NONE}, 1'b1, '{7'd126, 1'b1, 1'b0, 1'b0, 1'b0}},
      '{ROW_CSR, REG_SPARE_FIRST, 16'hFFFF, '0, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{1'b1, 7'd127, BTN_NONE}, 1'b1, '{7'd127, 1'b1, 1'b0, 1'b0, 1'b0}},
      '{ROW_CSR, REG_MANUAL_RUN, 16'd0, '0, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{1'b0, 7'd0, BTN_MODE}, 1'b1, '{7'd127, 1'b0, 1'b1, 1'b0, 1'b0}},
      '{ROW_ITEM, '0, '0, '{1'b1, 7'd0, BTN_WATER}, 1'b1, '{7'd127, 1'b0, 1'b1, 1'b0, 1'b0}},
      '{ROW_ITEM, '0, '0, '{1'b1, 7'd100, BTN_MODE}, 1'b0, '0}
   };

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   cfg_type pump_cfg = '{LOW_THRESHOLD_RST, HIGH_THRESHOLD_RST, MAX_WATER_RST,
                         CHECK_INTERVAL_RST, MANUAL_RUN_RST};
   state_type ctl = STATE_RST;

   result_type expected_status_q[$];
   int  error_count      = 0;
   int  cycle_count      = 0;
   int  send_idle_pct    = 0;
   int  recv_idle_pct    = 0;
   bit  long_stall_armed = 1'b0;

   irrigation_pump_controller u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // One poll pass of the controller: advance timers, take the button, run the mode logic.
   function automatic result_type water_step(input item_type it);
      result_type r;
      logic       took_sample;
      took_sample = 1'b0;
      if (it.second_tick) begin
         if (ctl.sample_timer != '1) ctl.sample_timer = ctl.sample_timer + 1'b1;
         if (ctl.run_timer != '1) ctl.run_timer = ctl.run_timer + 1'b1;
      end
      if (it.button == BTN_MODE) begin
         if (!ctl.manual_mode) begin
            ctl.manual_mode  = 1'b1;
            ctl.pump_running = 1'b0;
         end else begin
            ctl.manual_mode = 1'b0;
         end
      end else if (it.button == BTN_WATER && ctl.manual_mode) begin
         ctl.pump_running = 1'b1;
         ctl.run_timer    = '0;
      end
      if (!ctl.manual_mode) begin
         if (ctl.sample_timer >= pump_cfg.check_interval_seconds) begin
            ctl.held_level   = it.humidity_sample;
            ctl.sample_timer = '0;
            took_sample      = 1'b1;
            if (ctl.held_level < pump_cfg.low_threshold && !ctl.pump_running) begin
               ctl.pump_running = 1'b1;
               ctl.led_state    = 1'b1;
               ctl.run_timer    = '0;
            end
         end
         if (ctl.pump_running && (ctl.held_level >= pump_cfg.high_threshold ||
                                  ctl.run_timer >= pump_cfg.max_water_seconds)) begin
            ctl.pump_running = 1'b0;
            ctl.led_state    = 1'b0;
         end
      end else if (ctl.pump_running && ctl.run_timer >= pump_cfg.manual_run_seconds) begin
         ctl.pump_running = 1'b0;
         ctl.led_state    = 1'b0;
      end
      r.pump_on       = ctl.pump_running;
      r.indicator_on  = ctl.led_state;
      r.manual_active = ctl.manual_mode;
      r.sampled       = took_sample;
      r.humidity_held = ctl.held_level;
      return r;
   endfunction

   function automatic item_type random_item();
      item_type it;
      int       pick;
      pick = $urandom_range(99);
      if (pick < 85) it.button = BTN_NONE;
      else if (pick < 91) it.button = BTN_MODE;
      else if (pick < 98) it.button = BTN_WATER;
      else it.button = BTN_SPARE;
      // mostly sensor-range readings, some with the top bits set
      it.humidity_sample = ($urandom_range(9) < 7) ? 7'($urandom_range(100)) : 7'($urandom);
      it.second_tick     = 1'($urandom_range(1));
      return it;
   endfunction

   function automatic void compare_field(input string name, input logic [6:0] want,
                                         input logic [6:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   task automatic send_item(input item_type it, input logic has_exp, input result_type exp);
      result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(it);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = water_step(it);
      expected_status_q.push_back(has_exp ? exp : predicted);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      unique case (idx)
         REG_LOW_THRESHOLD:  pump_cfg.low_threshold          = val[LEVEL_W-1:0];
         REG_HIGH_THRESHOLD: pump_cfg.high_threshold         = val[LEVEL_W-1:0];
         REG_MAX_WATER:      pump_cfg.max_water_seconds      = val;
         REG_CHECK_INTERVAL: pump_cfg.check_interval_seconds = val;
         REG_MANUAL_RUN:     pump_cfg.manual_run_seconds     = val;
         default: ;
      endcase
   endtask

   task automatic configure_phase(input int p);
      logic [LEVEL_W-1:0] lo, hi;
      logic [TIMER_W-1:0] mx, ck, mr;
      unique case (p)
         0: begin
            lo = 7'(30 + $urandom_range(20));
            hi = 7'(55 + $urandom_range(30));
            mx = 16'(5 + $urandom_range(20));
            ck = 16'($urandom_range(3));
            mr = 16'(3 + $urandom_range(10));
         end
         1: begin
            lo = '0;
            hi = 7'($urandom);
            mx = '1;
            ck = '0;
            mr = '1;
         end
         2: begin
            lo = 7'd100;
            hi = 7'd100;
            mx = 16'(1 + $urandom_range(3));
            ck = 16'($urandom_range(2));
            mr = '0;
         end
         3: begin
            lo = 7'($urandom);
            hi = 7'($urandom);
            mx = 16'($urandom_range(40));
            ck = 16'($urandom_range(4));
            mr = 16'($urandom_range(20));
         end
         4: begin
            lo = 7'(50 + $urandom_range(50));
            hi = '1;
            mx = 16'(1 + $urandom_range(8));
            ck = 16'($urandom_range(1));
            mr = 16'($urandom_range(5));
         end
         default: begin
            lo = '1;
            hi = '0;
            mx = '0;
            ck = '0;
            mr = 16'd1;
         end
      endcase
      wait_drained();
      // junk in the upper bits of the narrow registers must be dropped
      write_reg(REG_LOW_THRESHOLD, {9'($urandom), lo});
      write_reg(REG_HIGH_THRESHOLD, {9'($urandom), hi});
      write_reg(REG_MAX_WATER, mx);
      write_reg(REG_CHECK_INTERVAL, ck);
      write_reg(REG_MANUAL_RUN, mr);
      write_reg(3'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)), 16'($urandom));
      csr_we <= 1'b0;
   endtask

   // Result side: check each transaction, then pick the next ready level.
   initial begin : rsp_side
      int         stall_left;
      bit         long_stall_done;
      result_type got, want;
      stall_left      = 0;
      long_stall_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(result_type)-1:0];
            if (expected_status_q.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual %h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = expected_status_q.pop_front();
               compare_field("pump_on", 7'(want.pump_on), 7'(got.pump_on));
               compare_field("indicator_on", 7'(want.indicator_on), 7'(got.indicator_on));
               compare_field("manual_active", 7'(want.manual_active), 7'(got.manual_active));
               compare_field("sampled", 7'(want.sampled), 7'(got.sampled));
               compare_field("humidity_held", want.humidity_held, got.humidity_held);
               compare_field("zero fill", '0, 7'(rsp_tdata[RSP_DATA_W-1:$bits(result_type)]));
            end
         end
         if (long_stall_armed && !long_stall_done) begin
            stall_left      = LONG_STALL_CYCLES;
            long_stall_done = 1'b1;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin : req_side
      send_idle_pct = 34;
      recv_idle_pct = 46;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (OPENING_ROWS[i]) begin
         if (OPENING_ROWS[i].kind == ROW_CSR) begin
            wait_drained();
            write_reg(OPENING_ROWS[i].csr_idx, OPENING_ROWS[i].csr_val);
            csr_we <= 1'b0;
         end else begin
            send_item(OPENING_ROWS[i].item, OPENING_ROWS[i].has_exp, OPENING_ROWS[i].exp);
         end
      end

      for (int p = 0; p < 6; p++) begin
         send_idle_pct = (p < 2) ? 34 : (p < 4) ? 46 : 0;
         recv_idle_pct = (p < 2) ? 46 : (p < 4) ? 34 : 0;
         configure_phase(p);
         // back-pressure the result side long enough to fill the pipe
         if (p == 0) long_stall_armed = 1'b1;
         repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, '0);
      end

      wait_drained();
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ipc_pkg.sv
rtl/ipc_csr.sv
rtl/ipc_step.sv
rtl/irrigation_pump_controller.sv
dv/tb_irrigation_pump_controller.sv
